// ===== sv/mmn_pkg.sv =====
package mmn_pkg;

   // default store dimensions
   localparam int DEF_MAX_ROWS = 64;
   localparam int DEF_MAX_COLS = 64;

   // field widths
   localparam int DIM_W      = 7;
   localparam int PIX_W      = 8;
   localparam int NORM_W     = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CHANNELS   = 3;
   localparam int CH_W       = 2;

   // register reset values and min/max start values
   localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(64);
   localparam logic [PIX_W-1:0] PIX_MAX   = '1;
   localparam logic [PIX_W-1:0] PIX_MIN   = '0;

   // reciprocal: recip = ceil(2^RECIP_BITS / range), exact for 23-bit dividends
   localparam int RECIP_BITS = 31;
   localparam int RECIP_W    = RECIP_BITS + 1;
   localparam int STEP_W     = $clog2(RECIP_BITS + 1);
   localparam int FRAC_W     = 15;
   localparam int Q_SHIFT    = RECIP_BITS - FRAC_W;
   localparam int PROD_W     = PIX_W + RECIP_W;
   localparam int QUO_W      = PROD_W - Q_SHIFT;
   localparam int FULL_SCALE = 32768;
   localparam int HALF_SCALE = 16384;

   // register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_IMAGE_ROWS = 2'd0,
      CSR_IMAGE_COLS = 2'd1
   } csr_index_type;

   // beat kind on the request channel
   typedef enum logic {
      MODE_LOAD = 1'b0,
      MODE_EMIT = 1'b1
   } mode_type;

   // controller to datapath
   typedef struct packed {
      logic restart;
      logic load_en;
      logic recip_start;
      logic recip_step;
      logic emit_read;
      logic mult_en;
      logic out_load;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic load_full;
      logic recip_done;
      logic emit_last;
   } status_type;

endpackage

// ===== sv/mmn_if.sv =====
// request channel: pixel loads and emit requests
interface mmn_req_if;
   logic                          valid;
   logic                          ready;
   mmn_pkg::mode_type             mode;
   logic [mmn_pkg::PIX_W-1:0]     pixel_value;

   modport source (output valid, output mode, output pixel_value, input ready);
   modport sink   (input valid, input mode, input pixel_value, output ready);
endinterface

// result channel: normalized values
interface mmn_rsp_if;
   logic                          valid;
   logic                          ready;
   logic signed [mmn_pkg::NORM_W-1:0] norm_value;
   logic                          last_value;

   modport source (output valid, output norm_value, output last_value, input ready);
   modport sink   (input valid, input norm_value, input last_value, output ready);
endinterface

// register write channel
interface mmn_csr_if;
   logic                          valid;
   logic                          ready;
   mmn_pkg::csr_index_type        index;
   logic [mmn_pkg::DIM_W-1:0]     data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== sv/min_max_image_normalizer.sv =====
// min/max image normalizer
// req_if carries load beats (mode 0, one interleaved channel byte each) and
// emit beats (mode 1). Loads are taken one per cycle until rows*cols*3 bytes
// have arrived; the block then computes the reciprocal of max-min, holding
// req_if.ready low meanwhile. Emit beats then return the image in planar
// order (channel, row, column) on rsp_if as (p-min)/range-0.5 in Q1.15, with
// last_value on the final value. An emit beat goes through the store read,
// the 8x32 multiply stage and the output register; the next emit beat is
// taken only after the one before reaches the output register. Emit beats while
// loading and load beats while emitting are taken and dropped. After the last
// value, or after a rows or cols write on csr_if, the block starts a new load
// with min/max cleared. Reset sets rows and cols to 64 and starts loading.
// When rsp_if.ready is low a finished value waits in the output register and
// the next value waits in the multiply stage until the output frees up.
// csr_if is always ready.
module min_max_image_normalizer #(
   parameter int MAX_ROWS = mmn_pkg::DEF_MAX_ROWS,
   parameter int MAX_COLS = mmn_pkg::DEF_MAX_COLS
) (
   input logic        clock,
   input logic        reset,
   mmn_req_if.sink    req_if,
   mmn_rsp_if.source  rsp_if,
   mmn_csr_if.sink    csr_if
);

   mmn_pkg::cmd_type    cmd;
   mmn_pkg::status_type status;

   assign csr_if.ready = 1'b1;

   // sequencing and handshakes
   mmn_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_mode  (req_if.mode),
      .req_ready (req_if.ready),
      .csr_valid (csr_if.valid),
      .csr_index (csr_if.index),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // store, min/max, reciprocal and scaling
   mmn_datapath #(
      .MAX_ROWS (MAX_ROWS),
      .MAX_COLS (MAX_COLS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .csr_valid   (csr_if.valid),
      .csr_index   (csr_if.index),
      .csr_data    (csr_if.data),
      .pixel_value (req_if.pixel_value),
      .cmd         (cmd),
      .status      (status),
      .norm_value  (rsp_if.norm_value),
      .last_value  (rsp_if.last_value)
   );

endmodule

// ===== sv/mmn_ram.sv =====
module mmn_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 12288
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/mmn_ctrl.sv =====
module mmn_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  mmn_pkg::mode_type      req_mode,
   output logic                   req_ready,
   input  logic                   csr_valid,
   input  mmn_pkg::csr_index_type csr_index,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  mmn_pkg::status_type    status,
   output mmn_pkg::cmd_type       cmd
);

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_RECIP,
      ST_EMIT,
      ST_READ,
      ST_MULT
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      req_fire;
   logic      csr_hit;
   logic      out_free;

   // handshake decode
   assign req_ready = (state_ff == ST_LOAD) || (state_ff == ST_EMIT);
   assign req_fire  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      csr_hit = 1'b0;
      if (csr_valid) begin
         unique case (csr_index)
            mmn_pkg::CSR_IMAGE_ROWS,
            mmn_pkg::CSR_IMAGE_COLS: csr_hit = 1'b1;
            default:                 csr_hit = 1'b0;
         endcase
      end
   end

   // datapath commands
   always_comb begin
      cmd             = '0;
      cmd.load_en     = (state_ff == ST_LOAD) && req_fire &&
                        (req_mode == mmn_pkg::MODE_LOAD) && !csr_hit;
      cmd.recip_start = cmd.load_en && status.load_full;
      cmd.recip_step  = (state_ff == ST_RECIP);
      cmd.emit_read   = (state_ff == ST_EMIT) && req_fire &&
                        (req_mode == mmn_pkg::MODE_EMIT) && !csr_hit;
      cmd.mult_en     = (state_ff == ST_READ);
      cmd.out_load    = (state_ff == ST_MULT) && out_free;
      cmd.restart     = csr_hit || (cmd.out_load && status.emit_last);
   end

   // next state
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end
      unique case (state_ff)
         ST_LOAD: begin
            if (cmd.recip_start) begin
               state_in = ST_RECIP;
            end
         end
         ST_RECIP: begin
            if (status.recip_done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (cmd.emit_read) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_MULT;
         end
         ST_MULT: begin
            if (cmd.out_load) begin
               state_in = status.emit_last ? ST_LOAD : ST_EMIT;
            end
         end
         default: state_in = ST_LOAD;
      endcase
      if (csr_hit) begin
         state_in = ST_LOAD;
      end
   end

   // state and output valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== sv/mmn_datapath.sv =====
module mmn_datapath #(
   parameter int MAX_ROWS = mmn_pkg::DEF_MAX_ROWS,
   parameter int MAX_COLS = mmn_pkg::DEF_MAX_COLS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_valid,
   input  mmn_pkg::csr_index_type          csr_index,
   input  logic [mmn_pkg::DIM_W-1:0]       csr_data,
   input  logic [mmn_pkg::PIX_W-1:0]       pixel_value,
   input  mmn_pkg::cmd_type                cmd,
   output mmn_pkg::status_type             status,
   output logic signed [mmn_pkg::NORM_W-1:0] norm_value,
   output logic                            last_value
);

   localparam int DEPTH     = MAX_ROWS * MAX_COLS * mmn_pkg::CHANNELS;
   localparam int NPIX_MAX  = MAX_ROWS * MAX_COLS;
   localparam int AW        = $clog2(DEPTH);
   localparam int CNT_W     = $clog2(DEPTH + 1);
   localparam int PCNT_W    = $clog2(NPIX_MAX + 1);
   localparam int ROW_W     = $clog2(MAX_ROWS + 1);
   localparam int COL_W     = $clog2(MAX_COLS + 1);
   localparam int PW        = mmn_pkg::PIX_W;

   logic [mmn_pkg::DIM_W-1:0]   rows_ff, rows_in, cols_ff, cols_in;
   logic [ROW_W-1:0]            rows_use;
   logic [COL_W-1:0]            cols_use;
   logic [PCNT_W-1:0]           npix;
   logic [CNT_W-1:0]            total;

   logic [PW-1:0]               min_ff, min_in, max_ff, max_in;
   logic [CNT_W-1:0]            load_cnt_ff, load_cnt_in;

   logic [PW-1:0]               range_calc, range_ff, range_in;
   logic [PW-1:0]               rem_ff, rem_in, rem_step;
   logic [PW:0]                 trial;
   logic                        ge;
   logic [mmn_pkg::RECIP_BITS-1:0] quo_ff, quo_in;
   logic [mmn_pkg::STEP_W-1:0]  step_ff, step_in;
   logic [mmn_pkg::RECIP_W-1:0] recip_ff, recip_in;

   logic [mmn_pkg::CH_W-1:0]    ch_ff, ch_in;
   logic [PCNT_W-1:0]           pix_ff, pix_in;
   logic [AW-1:0]               addr_ff, addr_in;
   logic [CNT_W-1:0]            emit_cnt_ff, emit_cnt_in;
   logic                        last_ff, last_in;

   logic [PW-1:0]               rd_data;
   logic [PW-1:0]               diff;
   logic [mmn_pkg::PROD_W-1:0]  diff_ext, recip_ext, prod_ff, prod_in;
   logic [mmn_pkg::QUO_W-1:0]   quot;
   logic signed [mmn_pkg::NORM_W-1:0] norm_ff, norm_in;
   logic                        last_out_ff, last_out_in;

   // dimensions in use, clamped to 1..max
   always_comb begin
      if (rows_ff == '0) begin
         rows_use = ROW_W'(1);
      end else if (int'(rows_ff) > MAX_ROWS) begin
         rows_use = ROW_W'(MAX_ROWS);
      end else begin
         rows_use = ROW_W'(rows_ff);
      end
      if (cols_ff == '0) begin
         cols_use = COL_W'(1);
      end else if (int'(cols_ff) > MAX_COLS) begin
         cols_use = COL_W'(MAX_COLS);
      end else begin
         cols_use = COL_W'(cols_ff);
      end
      npix  = PCNT_W'(int'(rows_use) * int'(cols_use));
      total = CNT_W'(int'(npix) * mmn_pkg::CHANNELS);
   end

   // register writes
   always_comb begin
      rows_in = rows_ff;
      cols_in = cols_ff;
      if (csr_valid) begin
         unique case (csr_index)
            mmn_pkg::CSR_IMAGE_ROWS: rows_in = csr_data;
            mmn_pkg::CSR_IMAGE_COLS: cols_in = csr_data;
            default: ;
         endcase
      end
   end

   // load side: min/max tracking and write pointer
   always_comb begin
      min_in      = min_ff;
      max_in      = max_ff;
      load_cnt_in = load_cnt_ff;
      if (cmd.restart) begin
         min_in      = mmn_pkg::PIX_MAX;
         max_in      = mmn_pkg::PIX_MIN;
         load_cnt_in = '0;
      end else if (cmd.load_en) begin
         if (pixel_value < min_ff) begin
            min_in = pixel_value;
         end
         if (pixel_value > max_ff) begin
            max_in = pixel_value;
         end
         load_cnt_in = load_cnt_ff + CNT_W'(1);
      end
   end

   assign status.load_full =
      ({1'b0, load_cnt_ff} + (CNT_W + 1)'(1)) >= {1'b0, total};

   // reciprocal unit: one quotient bit per cycle, then round up
   assign range_calc = (max_in > min_in) ? (max_in - min_in) : PW'(1);
   assign trial      = {rem_ff, 1'b1};
   assign ge         = trial >= {1'b0, range_ff};
   assign rem_step   = ge ? PW'(trial - {1'b0, range_ff}) : PW'(trial);

   always_comb begin
      range_in = range_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      step_in  = step_ff;
      recip_in = recip_ff;
      if (cmd.recip_start) begin
         range_in = range_calc;
         rem_in   = '0;
         quo_in   = '0;
         step_in  = '0;
      end else if (cmd.recip_step) begin
         if (status.recip_done) begin
            recip_in = {1'b0, quo_ff} + mmn_pkg::RECIP_W'(1);
         end else begin
            rem_in  = rem_step;
            quo_in  = {quo_ff[mmn_pkg::RECIP_BITS-2:0], ge};
            step_in = step_ff + mmn_pkg::STEP_W'(1);
         end
      end
   end

   assign status.recip_done = (step_ff == mmn_pkg::STEP_W'(mmn_pkg::RECIP_BITS));

   // planar read order: channel, then pixel within the channel
   always_comb begin
      ch_in       = ch_ff;
      pix_in      = pix_ff;
      addr_in     = addr_ff;
      emit_cnt_in = emit_cnt_ff;
      last_in     = last_ff;
      if (cmd.restart) begin
         ch_in       = '0;
         pix_in      = '0;
         addr_in     = '0;
         emit_cnt_in = '0;
      end else if (cmd.emit_read) begin
         last_in     = ({1'b0, emit_cnt_ff} + (CNT_W + 1)'(1)) >= {1'b0, total};
         emit_cnt_in = emit_cnt_ff + CNT_W'(1);
         if (({1'b0, pix_ff} + (PCNT_W + 1)'(1)) >= {1'b0, npix}) begin
            pix_in  = '0;
            ch_in   = ch_ff + mmn_pkg::CH_W'(1);
            addr_in = AW'(ch_ff) + AW'(1);
         end else begin
            pix_in  = pix_ff + PCNT_W'(1);
            addr_in = addr_ff + AW'(mmn_pkg::CHANNELS);
         end
      end
   end

   assign status.emit_last = last_ff;

   mmn_ram #(
      .WIDTH (PW),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (cmd.load_en),
      .wr_addr (load_cnt_ff[AW-1:0]),
      .wr_data (pixel_value),
      .rd_en   (cmd.emit_read),
      .rd_addr (addr_ff),
      .rd_data (rd_data)
   );

   // offset from min, scaled by the reciprocal
   assign diff      = (rd_data > min_ff) ? (rd_data - min_ff) : '0;
   assign diff_ext  = mmn_pkg::PROD_W'(diff);
   assign recip_ext = mmn_pkg::PROD_W'(recip_ff);
   assign prod_in   = cmd.mult_en ? (diff_ext * recip_ext) : prod_ff;

   // quotient minus one half, clamped at the top
   assign quot = prod_ff[mmn_pkg::PROD_W-1:mmn_pkg::Q_SHIFT];

   always_comb begin
      norm_in     = norm_ff;
      last_out_in = last_out_ff;
      if (cmd.out_load) begin
         if (quot > mmn_pkg::QUO_W'(mmn_pkg::FULL_SCALE)) begin
            norm_in = mmn_pkg::NORM_W'(mmn_pkg::HALF_SCALE);
         end else begin
            norm_in = mmn_pkg::NORM_W'(quot) - mmn_pkg::NORM_W'(mmn_pkg::HALF_SCALE);
         end
         last_out_in = last_ff;
      end
   end

   // control-side registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff     <= mmn_pkg::DIM_RESET;
         cols_ff     <= mmn_pkg::DIM_RESET;
         min_ff      <= mmn_pkg::PIX_MAX;
         max_ff      <= mmn_pkg::PIX_MIN;
         load_cnt_ff <= '0;
         step_ff     <= '0;
         ch_ff       <= '0;
         pix_ff      <= '0;
         addr_ff     <= '0;
         emit_cnt_ff <= '0;
      end else begin
         rows_ff     <= rows_in;
         cols_ff     <= cols_in;
         min_ff      <= min_in;
         max_ff      <= max_in;
         load_cnt_ff <= load_cnt_in;
         step_ff     <= step_in;
         ch_ff       <= ch_in;
         pix_ff      <= pix_in;
         addr_ff     <= addr_in;
         emit_cnt_ff <= emit_cnt_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      range_ff    <= range_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      recip_ff    <= recip_in;
      last_ff     <= last_in;
      prod_ff     <= prod_in;
      norm_ff     <= norm_in;
      last_out_ff <= last_out_in;
   end

   assign norm_value = norm_ff;
   assign last_value = last_out_ff;

endmodule
